>>> src/dip_pkg.sv
// Shared types and character constants for the dotted IPv4 string parser.
`default_nettype none

package dip_pkg;

  typedef enum logic [1:0] {
    PhStart  = 2'd0,
    PhZero   = 2'd1,
    PhDigits = 2'd2,
    PhTrail  = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    RxDec = 2'd0,
    RxOct = 2'd1,
    RxHex = 2'd2
  } radix_e;

  localparam int unsigned NumStored = 3;
  localparam logic [1:0] LastStoredCnt = 2'd3;

  localparam logic [7:0] ChNul   = 8'h00;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChDot   = 8'h2e;
  localparam logic [7:0] ChLowX  = 8'h78;
  localparam logic [7:0] ChUpX   = 8'h58;
  localparam logic [7:0] ChLowA  = 8'h61;
  localparam logic [7:0] ChLowF  = 8'h66;
  localparam logic [7:0] ChUpA   = 8'h41;
  localparam logic [7:0] ChUpF   = 8'h46;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChLf    = 8'h0a;
  localparam logic [7:0] ChFf    = 8'h0c;
  localparam logic [7:0] ChBs    = 8'h08;
  localparam logic [7:0] ChCr    = 8'h0d;

  localparam logic [3:0] LetterOffset = 4'd9;

  function automatic logic is_blank(input logic [7:0] c);
    return (c == ChSpace) || (c == ChTab) || (c == ChLf) ||
           (c == ChFf) || (c == ChBs) || (c == ChCr);
  endfunction

endpackage

`default_nettype wire

>>> src/dip_in_if.sv
// Character input channel: valid/ready with one byte of payload.
`default_nettype none

interface dip_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;

  modport source (output valid, output ch, input ready);
  modport sink   (input valid, input ch, output ready);
endinterface

`default_nettype wire

>>> src/dip_out_if.sv
// Result channel: valid/ready with the ok flag and the parsed address.
`default_nettype none

interface dip_out_if;
  logic        valid;
  logic        ready;
  logic        ok;
  logic [31:0] address;

  modport source (output valid, output ok, output address, input ready);
  modport sink   (input valid, input ok, input address, output ready);
endinterface

`default_nettype wire

>>> src/dotted_ipv4_string_parser_core.sv
// Top level of the dotted IPv4 string parser: input register, parse step, result register.
//
//  channel | dir | payload            | transfer when
//  in_i    | in  | ch[7:0]            | in_i.valid && in_i.ready
//  out_o   | out | ok, address[31:0]  | out_o.valid && out_o.ready
//
// One character per cycle while no terminator waits on a stalled result; a
// terminator passes the input register, then its result the result register.
// The parse step reads and updates the part state once per character.
// rst_ni clears the pipeline valids and the parse state asynchronously.
// A stalled result holds only a terminator in the input register; other
// characters keep flowing while the result waits.
`default_nettype none

module dotted_ipv4_string_parser_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  dip_in_if.sink     in_i,
  dip_out_if.source  out_o
);
  import dip_pkg::*;

  // input register
  logic       s1_valid_q;
  logic [7:0] ch_q;

  // parse state
  phase_e      phase_q, phase_d;
  radix_e      radix_q, radix_d;
  logic [31:0] part_value_q, part_value_d;
  logic [1:0]  part_count_q, part_count_d;
  logic        failed_q, failed_d;
  logic [7:0]  stored_q [NumStored];
  logic        store_we;

  // result register
  logic        out_valid_q;
  logic        out_ok_q;
  logic [31:0] out_addr_q;

  logic        term;
  logic        out_free;
  logic        step;
  logic        res_ok;
  logic [31:0] res_addr;

  assign term     = (ch_q == ChNul);
  assign out_free = !out_valid_q || out_o.ready;
  assign step     = s1_valid_q && (!term || out_free);
  assign in_i.ready = !s1_valid_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      ch_q <= in_i.ch;
    end
  end

  // Next parse state for the character in the input register.
  always_comb begin
    logic        take;
    radix_e      eff_radix;
    logic [31:0] base;
    logic [31:0] scaled;
    logic [3:0]  digit;

    phase_d      = phase_q;
    radix_d      = radix_q;
    part_value_d = part_value_q;
    part_count_d = part_count_q;
    failed_d     = failed_q;
    store_we     = 1'b0;
    take         = 1'b0;
    eff_radix    = radix_q;
    base         = part_value_q;
    scaled       = '0;
    digit        = '0;

    if (term) begin
      phase_d      = PhStart;
      radix_d      = RxDec;
      part_value_d = '0;
      part_count_d = '0;
      failed_d     = 1'b0;
    end else if (!failed_q && phase_q != PhTrail) begin
      case (phase_q)
        PhStart: begin
          base         = '0;
          part_value_d = '0;
          if (ch_q == ChZero) begin
            phase_d = PhZero;
          end else begin
            eff_radix = RxDec;
            radix_d   = RxDec;
            take      = 1'b1;
          end
        end
        PhZero: begin
          if (ch_q == ChLowX || ch_q == ChUpX) begin
            radix_d = RxHex;
            phase_d = PhDigits;
          end else begin
            eff_radix = RxOct;
            radix_d   = RxOct;
            take      = 1'b1;
          end
        end
        default: take = 1'b1;
      endcase

      if (take) begin
        phase_d = PhDigits;
        case (eff_radix)
          RxHex:   scaled = base << 4;
          RxOct:   scaled = base << 3;
          default: scaled = (base << 3) + (base << 1);
        endcase

        if (ch_q inside {[ChZero:ChNine]}) begin
          digit        = ch_q[3:0];
          part_value_d = scaled + {28'd0, digit};
        end else if (eff_radix == RxHex &&
                     (ch_q inside {[ChLowA:ChLowF]} || ch_q inside {[ChUpA:ChUpF]})) begin
          digit        = ch_q[3:0] + LetterOffset;
          part_value_d = scaled + {28'd0, digit};
        end else if (ch_q == ChDot) begin
          if (part_count_q == LastStoredCnt || base[31:8] != 24'd0) begin
            failed_d = 1'b1;
          end else begin
            store_we     = 1'b1;
            part_count_d = part_count_q + 2'd1;
            part_value_d = '0;
            radix_d      = RxDec;
            phase_d      = PhStart;
          end
        end else if (is_blank(ch_q)) begin
          phase_d = PhTrail;
        end else begin
          failed_d = 1'b1;
        end
      end
    end
  end

  // Result for a terminator: merge stored bytes under the last part.
  always_comb begin
    res_ok   = !failed_q;
    res_addr = part_value_q;
    case (part_count_q)
      2'd0: ;
      2'd1: begin
        res_ok   = res_ok && (part_value_q[31:24] == 8'd0);
        res_addr = {stored_q[0], part_value_q[23:0]};
      end
      2'd2: begin
        res_ok   = res_ok && (part_value_q[31:16] == 16'd0);
        res_addr = {stored_q[0], stored_q[1], part_value_q[15:0]};
      end
      default: begin
        res_ok   = res_ok && (part_value_q[31:8] == 24'd0);
        res_addr = {stored_q[0], stored_q[1], stored_q[2], part_value_q[7:0]};
      end
    endcase
    if (!res_ok) begin
      res_addr = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PhStart;
      radix_q      <= RxDec;
      part_value_q <= '0;
      part_count_q <= '0;
      failed_q     <= 1'b0;
    end else if (step) begin
      phase_q      <= phase_d;
      radix_q      <= radix_d;
      part_value_q <= part_value_d;
      part_count_q <= part_count_d;
      failed_q     <= failed_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && store_we) begin
      stored_q[part_count_q] <= part_value_q[7:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= step && term;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && step && term) begin
      out_ok_q   <= res_ok;
      out_addr_q <= res_addr;
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.ok      = out_ok_q;
  assign out_o.address = out_addr_q;

  // A failed result never carries an address.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ok_q |-> out_addr_q == 32'd0)
    else $error("failed result with nonzero address");

  // A terminator clears the parse state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && term |=> part_count_q == 2'd0 && !failed_q && part_value_q == 32'd0)
    else $error("parse state not cleared after terminator");

  // After a leading zero the part value is still zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PhZero |-> part_value_q == 32'd0)
    else $error("nonzero part value after leading zero");

  // Once failed, no more parts are stored until the terminator.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    failed_q && !(step && term) |=> $stable(part_count_q) && failed_q)
    else $error("parse state moved after failure");

  // An empty input register always takes a new character.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_valid_q |-> in_i.ready)
    else $error("input stalled with empty input register");

endmodule

`default_nettype wire
